@@ hdl/tsrt_pkg.sv @@
package tsrt_pkg;

	// Command codes carried in s_tuser
	typedef enum logic [1:0] {
		CMD_UPDATE     = 2'd0,
		CMD_INVALIDATE = 2'd1,
		CMD_QUERY      = 2'd2
	} tsrt_cmd_t;

	// Sequencer states
	typedef enum logic [1:0] {
		ST_IDLE = 2'd0,
		ST_LOAD = 2'd1,
		ST_DIV  = 2'd2,
		ST_DONE = 2'd3
	} tsrt_state_t;

	localparam int TIME_BITS   = 32;
	localparam int LIMIT_BITS  = 16;
	localparam int IN_VALUE_W  = 48;
	localparam int RATE_W      = 64;
	localparam int COUNT_BITS  = 2;
	localparam logic [COUNT_BITS-1:0] SAMPLES_NONE = 2'd0;
	localparam logic [COUNT_BITS-1:0] SAMPLES_MAX  = 2'd2;
	localparam logic [LIMIT_BITS-1:0] LIMIT_RESET  = 16'd60;

endpackage

@@ hdl/tsrt_store.sv @@
module tsrt_store
	import tsrt_pkg::*;
#(
	parameter int VALUE_BITS = 48
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  step,
	input  logic [1:0]            command,
	input  logic [VALUE_BITS-1:0] sample_value,
	input  logic [TIME_BITS-1:0]  sample_time,
	output logic [VALUE_BITS-1:0] newer_value,
	output logic [TIME_BITS-1:0]  newer_time,
	output logic [VALUE_BITS-1:0] older_value,
	output logic [TIME_BITS-1:0]  older_time,
	output logic [COUNT_BITS-1:0] valid_count
);

	logic [VALUE_BITS-1:0] newer_value_q, older_value_q;
	logic [TIME_BITS-1:0]  newer_time_q, older_time_q;
	logic [COUNT_BITS-1:0] count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			newer_value_q <= '0;
			newer_time_q  <= '0;
			older_value_q <= '0;
			older_time_q  <= '0;
			count_q       <= SAMPLES_NONE;
		end else if (step) begin
			case (command)
				CMD_UPDATE: begin
					if (count_q == SAMPLES_NONE) begin
						newer_value_q <= sample_value;
						newer_time_q  <= sample_time;
						count_q       <= COUNT_BITS'(1);
					end else if (newer_time_q < sample_time) begin
						// shift the newest sample down
						older_value_q <= newer_value_q;
						older_time_q  <= newer_time_q;
						newer_value_q <= sample_value;
						newer_time_q  <= sample_time;
						if (count_q != SAMPLES_MAX)
							count_q <= count_q + COUNT_BITS'(1);
					end
				end
				CMD_INVALIDATE: count_q <= SAMPLES_NONE;
				default: ;
			endcase
		end
	end

	assign newer_value = newer_value_q;
	assign newer_time  = newer_time_q;
	assign older_value = older_value_q;
	assign older_time  = older_time_q;
	assign valid_count = count_q;

endmodule

@@ hdl/tsrt_div.sv @@
module tsrt_div #(
	parameter int N = 64,
	parameter int D = 32
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [N-1:0] dividend,
	input  logic [D-1:0] divisor,
	output logic         done,
	output logic [N-1:0] quotient
);

	localparam int CW = $clog2(N + 1);

	logic [N-1:0]  quo_q;
	logic [D-1:0]  rem_q;
	logic [D-1:0]  den_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;
	logic [D:0]    trial;
	logic [D:0]    diff;
	logic          fits;

	// one quotient bit per cycle: shift in the next dividend bit, trial subtract
	assign trial = {rem_q, quo_q[N-1]};
	assign diff  = trial - {1'b0, den_q};
	assign fits  = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(N);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			den_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[N-2:0], fits};
			rem_q <= fits ? diff[D-1:0] : trial[D-1:0];
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

@@ hdl/two_sample_rate_tracker_top.sv @@
// Two-sample counter rate tracker. Each input transaction (update, invalidate
// or query, selected by s_tuser) produces exactly one output transaction with
// the newest counter value and the rate (newer - older value) / (newer - older
// time) in unsigned fixed point with FRACTION_BITS fraction bits, both gated by
// a freshness test: now_time - newest time, taken as a signed difference, must
// not exceed stale_limit_secs (written through cfg_wr_en / cfg_wr_data, reset
// 60). A falling counter gives rate 0 with rate_fresh still set. The divide is
// a radix-2 restoring unit producing one quotient bit per cycle. An item that
// needs a rate goes through ST_LOAD, ST_DIV and ST_DONE into the output
// register; any other item skips ST_DIV. A new transaction is taken once
// the previous one has left the divider and sits in the output register, so
// the output may stall without blocking the next item's work.
module two_sample_rate_tracker_top
	import tsrt_pkg::*;
#(
	parameter int VALUE_BITS    = 48,
	parameter int FRACTION_BITS = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [111:0]          s_tdata,   // sample_value[47:0], sample_time, now_time
	input  logic [1:0]            s_tuser,   // command
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [111:0]          m_tdata,   // rate[63:0], current_value[47:0]
	output logic [1:0]            m_tuser,   // rate_fresh, value_fresh
	input  logic                  cfg_wr_en,
	input  logic [LIMIT_BITS-1:0] cfg_wr_data
);

	localparam int N = VALUE_BITS + FRACTION_BITS;

	tsrt_state_t state_q, state_d;

	logic [LIMIT_BITS-1:0] limit_q;
	logic [TIME_BITS-1:0]  now_q;
	logic                  rate_ok_q, val_ok_q, use_div_q;

	logic [VALUE_BITS-1:0] newer_value, older_value;
	logic [TIME_BITS-1:0]  newer_time, older_time;
	logic [COUNT_BITS-1:0] valid_count;

	logic                  in_hs;
	logic                  fresh, rate_ok, val_ok, rising;
	logic signed [TIME_BITS:0] age;
	logic [VALUE_BITS-1:0] vdiff;
	logic [TIME_BITS-1:0]  span;
	logic [N-1:0]          dividend, quotient;
	logic                  div_start, div_done;
	logic                  out_free, out_load;

	logic [RATE_W-1:0]     rate_q;
	logic [IN_VALUE_W-1:0] cur_q;
	logic                  rate_fresh_q, value_fresh_q, m_tvalid_q;

	assign in_hs    = s_tvalid && s_tready;
	assign s_tready = (state_q == ST_IDLE);

	// Hold the stale limit; writes must arrive only while idle (not enforced here)
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			limit_q <= LIMIT_RESET;
		else if (cfg_wr_en)
			limit_q <= cfg_wr_data;
	end

	// Apply the command to the sample store at accept
	tsrt_store #(.VALUE_BITS(VALUE_BITS)) u_store (
		.clk          (clk),
		.arst_n       (arst_n),
		.step         (in_hs),
		.command      (s_tuser),
		.sample_value (s_tdata[VALUE_BITS-1:0]),
		.sample_time  (s_tdata[79:48]),
		.newer_value  (newer_value),
		.newer_time   (newer_time),
		.older_value  (older_value),
		.older_time   (older_time),
		.valid_count  (valid_count)
	);

	always_ff @(posedge clk) begin
		if (in_hs)
			now_q <= s_tdata[111:80];
	end

	// Freshness and rate operands, evaluated on the updated store in ST_LOAD
	assign age      = $signed({1'b0, now_q}) - $signed({1'b0, newer_time});
	assign fresh    = age <= $signed({{(TIME_BITS + 1 - LIMIT_BITS){1'b0}}, limit_q});
	assign val_ok   = (valid_count != SAMPLES_NONE) && fresh;
	assign rate_ok  = (valid_count == SAMPLES_MAX) && fresh;
	assign rising   = (newer_value > older_value) && (newer_time > older_time);
	assign vdiff    = newer_value - older_value;
	assign span     = newer_time - older_time;
	// the scaled difference always fits in N bits (64 at the defaults), so no saturation
	assign dividend = N'(vdiff) << FRACTION_BITS;
	assign div_start = (state_q == ST_LOAD) && rate_ok && rising;

	tsrt_div #(.N(N), .D(TIME_BITS)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (dividend),
		.divisor  (span),
		.done     (div_done),
		.quotient (quotient)
	);

	always_ff @(posedge clk) begin
		if (state_q == ST_LOAD) begin
			rate_ok_q <= rate_ok;
			val_ok_q  <= val_ok;
			use_div_q <= rate_ok && rising;
		end
	end

	assign out_free = !m_tvalid_q || m_tready;
	assign out_load = (state_q == ST_DONE) && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: if (in_hs) state_d = ST_LOAD;
			ST_LOAD: state_d = div_start ? ST_DIV : ST_DONE;
			ST_DIV:  if (div_done) state_d = ST_DONE;
			ST_DONE: if (out_free) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// Output register: hold the result until the sink takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			m_tvalid_q <= 1'b0;
		else if (out_load)
			m_tvalid_q <= 1'b1;
		else if (m_tready)
			m_tvalid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			rate_q        <= use_div_q ? RATE_W'(quotient) : '0;
			cur_q         <= val_ok_q ? IN_VALUE_W'(newer_value) : '0;
			rate_fresh_q  <= rate_ok_q;
			value_fresh_q <= val_ok_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {cur_q, rate_q};
	assign m_tuser  = {value_fresh_q, rate_fresh_q};

endmodule
